@@ hw/rtl/cprr_pkg.sv @@
// ============================================================================
// cprr_pkg - shared constants for the cursor position rotate/reflect block
// Register indexes, rotation codes and field widths that do not depend on
// the coordinate width parameter.
// ============================================================================
package cprr_pkg;

  // Default coordinate width of the input points.
  localparam int COORD_BITS_DEF = 16;

  // Width of the cursor image hotspot registers.
  localparam int HOT_BITS = 9;

  // Width of the rotation word and its fields.
  localparam int ROT_WORD_BITS  = 6;
  localparam int REFLECT_X_BIT  = 4;
  localparam int REFLECT_Y_BIT  = 5;

  // Configuration register indexes.
  localparam int NUM_REGS      = 7;
  localparam int CFG_IDX_BITS  = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE_W    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE_H    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOT_X     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOT_Y     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_HOT_X = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_HOT_Y = 3'd6;

  // One-hot rotation codes held in the low nibble of the rotation word.
  localparam logic [3:0] ROT_NIBBLE_MASK = 4'hf;
  localparam logic [3:0] ROT_0   = 4'h1;
  localparam logic [3:0] ROT_90  = 4'h2;
  localparam logic [3:0] ROT_180 = 4'h4;
  localparam logic [3:0] ROT_270 = 4'h8;

  // Reset values of the configuration registers.
  localparam logic [ROT_WORD_BITS-1:0] ROTATION_RST = 6'd1;
  localparam int MODE_W_RST = 1024;
  localparam int MODE_H_RST = 768;

  // Derived axis operation.
  typedef struct packed {
    logic swap;   // hardware X follows point Y
    logic neg_x;  // subtract the X term from the X offset
    logic neg_y;  // subtract the Y term from the Y offset
  } axis_op_t;

endpackage

@@ hw/rtl/cursor_position_rotate_reflect.sv @@
// ============================================================================
// cursor_position_rotate_reflect - cursor position mapper for rotated output
// Maps pointer coordinates to the hardware cursor upper-left position for a
// display that is rotated by a multiple of 90 degrees and optionally
// reflected in X and/or Y.
// ============================================================================
//
// The block takes one point item per cycle while the output side is not
// stalled and returns one position item for each; an item passes through the
// input register and then the result register, with a single signed add or
// subtract per axis between them. The configuration registers (rotation
// word, mode size, source hotspot relative to the CRTC origin and the
// hotspot inside the cursor image) are reduced every cycle to an axis
// operation (swap, negate X term, negate Y term) and two offsets, which are
// held in registers; those derived values follow a register write through
// these registers, and items already in flight are not held back meanwhile.
// A rotation nibble that is not exactly one of the four one-hot codes
// is treated as no rotation, while the reflect bits still apply; under a
// 90 or 270 degree rotation reflect X acts on the hardware Y axis and
// reflect Y on the hardware X axis. Results are truncated to COORD_BITS+1
// bits. Writes to an index past the last register are ignored.
//
module cursor_position_rotate_reflect
  import cprr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_wdata,
  // point input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  // position output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [COORD_BITS:0] out_hw_pos_x,
  output logic signed [COORD_BITS:0] out_hw_pos_y
);

  // Offsets need two bits beyond the coordinate: mode size minus a negative
  // coordinate, less the image hotspot.
  localparam int OFF_W  = COORD_BITS + 2;
  localparam int MODE_W = COORD_BITS - 1;
  localparam int RES_W  = COORD_BITS + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROT_WORD_BITS-1:0]     rot_word_r;
  logic [MODE_W-1:0]            mode_w_r;
  logic [MODE_W-1:0]            mode_h_r;
  logic signed [COORD_BITS-1:0] hot_x_r;
  logic signed [COORD_BITS-1:0] hot_y_r;
  logic [HOT_BITS-1:0]          img_hot_x_r;
  logic [HOT_BITS-1:0]          img_hot_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_word_r  <= ROTATION_RST;
      mode_w_r    <= MODE_W'(MODE_W_RST);
      mode_h_r    <= MODE_W'(MODE_H_RST);
      hot_x_r     <= '0;
      hot_y_r     <= '0;
      img_hot_x_r <= '0;
      img_hot_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROTATION:  rot_word_r  <= cfg_wdata[ROT_WORD_BITS-1:0];
        REG_MODE_W:    mode_w_r    <= cfg_wdata[MODE_W-1:0];
        REG_MODE_H:    mode_h_r    <= cfg_wdata[MODE_W-1:0];
        REG_HOT_X:     hot_x_r     <= cfg_wdata;
        REG_HOT_Y:     hot_y_r     <= cfg_wdata;
        REG_IMG_HOT_X: img_hot_x_r <= cfg_wdata[HOT_BITS-1:0];
        REG_IMG_HOT_Y: img_hot_y_r <= cfg_wdata[HOT_BITS-1:0];
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Derivation of the axis operation and the offsets
  // --------------------------------------------------------------------------
  // Rotation first sets which source axis feeds each hardware axis and
  // whether it is mirrored; the reflect bits then toggle the mirroring.
  // Mirroring X is always about the mode width and Y about the mode height.
  logic     rot_swap;
  logic     rot_neg_x;
  logic     rot_neg_y;
  logic     refl_x;
  logic     refl_y;
  axis_op_t axis_op_nxt;
  axis_op_t axis_op_r;

  always_comb begin
    rot_swap  = 1'b0;
    rot_neg_x = 1'b0;
    rot_neg_y = 1'b0;
    unique case (rot_word_r[3:0] & ROT_NIBBLE_MASK)
      ROT_90: begin
        rot_swap  = 1'b1;
        rot_neg_y = 1'b1;
      end
      ROT_180: begin
        rot_neg_x = 1'b1;
        rot_neg_y = 1'b1;
      end
      ROT_270: begin
        rot_swap  = 1'b1;
        rot_neg_x = 1'b1;
      end
      default: begin
        // Rotation 0, and any nibble that is not a single rotation code.
      end
    endcase
    // With the axes swapped the reflect bits trade places.
    refl_x = rot_swap ? rot_word_r[REFLECT_Y_BIT] : rot_word_r[REFLECT_X_BIT];
    refl_y = rot_swap ? rot_word_r[REFLECT_X_BIT] : rot_word_r[REFLECT_Y_BIT];
    axis_op_nxt.swap  = rot_swap;
    axis_op_nxt.neg_x = rot_neg_x ^ refl_x;
    axis_op_nxt.neg_y = rot_neg_y ^ refl_y;
  end

  // The source hotspot goes through the same transform.
  logic signed [OFF_W-1:0] hot_tx;
  logic signed [OFF_W-1:0] hot_ty;
  logic signed [OFF_W-1:0] mode_w_ext;
  logic signed [OFF_W-1:0] mode_h_ext;
  logic signed [OFF_W-1:0] base_x;
  logic signed [OFF_W-1:0] base_y;
  logic signed [OFF_W-1:0] offset_x_nxt;
  logic signed [OFF_W-1:0] offset_y_nxt;
  logic signed [OFF_W-1:0] offset_x_r;
  logic signed [OFF_W-1:0] offset_y_r;

  always_comb begin
    hot_tx     = rot_swap ? OFF_W'(hot_y_r) : OFF_W'(hot_x_r);
    hot_ty     = rot_swap ? OFF_W'(hot_x_r) : OFF_W'(hot_y_r);
    mode_w_ext = OFF_W'({1'b0, mode_w_r});
    mode_h_ext = OFF_W'({1'b0, mode_h_r});
    base_x     = axis_op_nxt.neg_x ? (mode_w_ext - OFF_W'(1) - hot_tx) : hot_tx;
    base_y     = axis_op_nxt.neg_y ? (mode_h_ext - OFF_W'(1) - hot_ty) : hot_ty;
    // The image hotspot moves the upper-left corner back from the hotspot.
    offset_x_nxt = base_x - OFF_W'({1'b0, img_hot_x_r});
    offset_y_nxt = base_y - OFF_W'({1'b0, img_hot_y_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_op_r  <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else begin
      axis_op_r  <= axis_op_nxt;
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Point path: input register, then result register
  // --------------------------------------------------------------------------
  logic                         in_vld_r;
  logic signed [COORD_BITS-1:0] pt_x_r;
  logic signed [COORD_BITS-1:0] pt_y_r;
  logic                         out_vld_r;
  logic signed [RES_W-1:0]      pos_x_r;
  logic signed [RES_W-1:0]      pos_y_r;
  logic                         res_adv;
  logic                         in_adv;

  // The result register takes a new item whenever it is empty or being
  // emptied; the input register likewise, so the pipe streams at full rate.
  assign res_adv  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || res_adv;
  assign in_adv   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      pt_x_r <= in_point_x;
      pt_y_r <= in_point_y;
    end
  end

  logic signed [OFF_W-1:0] term_x;
  logic signed [OFF_W-1:0] term_y;
  logic signed [OFF_W-1:0] sum_x;
  logic signed [OFF_W-1:0] sum_y;

  always_comb begin
    term_x = axis_op_r.swap ? OFF_W'(pt_y_r) : OFF_W'(pt_x_r);
    term_y = axis_op_r.swap ? OFF_W'(pt_x_r) : OFF_W'(pt_y_r);
    sum_x  = axis_op_r.neg_x ? (offset_x_r - term_x) : (offset_x_r + term_x);
    sum_y  = axis_op_r.neg_y ? (offset_y_r - term_y) : (offset_y_r + term_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv && in_vld_r) begin
      pos_x_r <= sum_x[RES_W-1:0];
      pos_y_r <= sum_y[RES_W-1:0];
    end
  end

  assign out_valid    = out_vld_r;
  assign out_hw_pos_x = pos_x_r;
  assign out_hw_pos_y = pos_y_r;

endmodule

@@ tb/cursor_position_rotate_reflect_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cursor_position_rotate_reflect_test - self-checking bench for the mapper
// Drives point items through the valid/ready input, sets up rotation,
// reflection, mode size and hotspot registers through the write port, and
// compares every position item with a behavioural prediction of the mapping.
// ============================================================================
module cursor_position_rotate_reflect_test;
  import cprr_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  // An index past the last register: writes to it must leave the state alone.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(NUM_REGS);
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [CB:0] x;
    logic [CB:0] y;
  } cursor_pos_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CB-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic signed [CB-1:0] in_point_x;
  logic signed [CB-1:0] in_point_y;
  logic out_valid;
  logic out_ready;
  logic signed [CB:0] out_hw_pos_x;
  logic signed [CB:0] out_hw_pos_y;

  cursor_position_rotate_reflect #(.COORD_BITS(CB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hw_pos_x (out_hw_pos_x),
    .out_hw_pos_y (out_hw_pos_y)
  );

  // Shadow copy of the configuration registers, held at their own widths so
  // that the masking of wide write data comes for free.
  logic [ROT_WORD_BITS-1:0] rot_word;
  logic [CB-2:0] mode_w;
  logic [CB-2:0] mode_h;
  logic signed [CB-1:0] src_hot_x;
  logic signed [CB-1:0] src_hot_y;
  logic [HOT_BITS-1:0] img_hot_x;
  logic [HOT_BITS-1:0] img_hot_y;

  // Placement derived from the registers: the axis operation and offsets.
  axis_op_t place_op;
  longint place_off_x;
  longint place_off_y;

  cursor_pos_t pending_positions[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ready_hold_left = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Takes one screen point through the display's rotation and reflection.
  // Under a quarter turn the axes are swapped, so each reflect bit then acts
  // on the other axis.
  function automatic void orient_point(inout longint x, inout longint y);
    longint w;
    longint h;
    longint t;
    bit swapped;
    w = longint'(mode_w);
    h = longint'(mode_h);
    swapped = 1'b0;
    case (rot_word[3:0])
      ROT_90: begin
        t = x; x = y; y = h - t - 1; swapped = 1'b1;
      end
      ROT_180: begin
        x = w - x - 1; y = h - y - 1;
      end
      ROT_270: begin
        t = x; x = w - y - 1; y = t; swapped = 1'b1;
      end
      // Anything that is not exactly one rotation code counts as no rotation.
      default: ;
    endcase
    if (swapped ? rot_word[REFLECT_Y_BIT] : rot_word[REFLECT_X_BIT]) x = w - x - 1;
    if (swapped ? rot_word[REFLECT_X_BIT] : rot_word[REFLECT_Y_BIT]) y = h - y - 1;
  endfunction

  // Recovers the signed axis operation by probing the transform at the
  // hotspot and one step along each axis, then sets the offsets to the
  // transformed hotspot less the image hotspot.
  function automatic void refresh_placement();
    longint x0, y0, x1, y1, x2, y2;
    longint ax, ay, cx, cy;
    x0 = longint'(src_hot_x); y0 = longint'(src_hot_y);
    x1 = x0 + 1;              y1 = y0;
    x2 = x0;                  y2 = y0 + 1;
    orient_point(x0, y0);
    orient_point(x1, y1);
    orient_point(x2, y2);
    ax = x1 - x0;
    ay = x2 - x0;
    cx = y1 - y0;
    cy = y2 - y0;
    if (ax != 0) begin
      place_op.swap  = 1'b0;
      place_op.neg_x = (ax < 0);
      place_op.neg_y = (cy < 0);
    end else begin
      place_op.swap  = 1'b1;
      place_op.neg_x = (ay < 0);
      place_op.neg_y = (cx < 0);
    end
    place_off_x = x0 - longint'(img_hot_x);
    place_off_y = y0 - longint'(img_hot_y);
  endfunction

  // Hardware cursor position for one point; results wrap at CB+1 bits.
  function automatic cursor_pos_t place_cursor(logic signed [CB-1:0] px,
                                               logic signed [CB-1:0] py);
    longint tx;
    longint ty;
    longint rx;
    longint ry;
    cursor_pos_t pos;
    tx = place_op.swap ? longint'(py) : longint'(px);
    ty = place_op.swap ? longint'(px) : longint'(py);
    rx = place_op.neg_x ? place_off_x - tx : place_off_x + tx;
    ry = place_op.neg_y ? place_off_y - ty : place_off_y + ty;
    pos.x = rx[CB:0];
    pos.y = ry[CB:0];
    return pos;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_BITS-1:0] idx,
                                         logic [CB-1:0] val);
    case (idx)
      REG_ROTATION:  rot_word  = val[ROT_WORD_BITS-1:0];
      REG_MODE_W:    mode_w    = val[CB-2:0];
      REG_MODE_H:    mode_h    = val[CB-2:0];
      REG_HOT_X:     src_hot_x = val;
      REG_HOT_Y:     src_hot_y = val;
      REG_IMG_HOT_X: img_hot_x = val[HOT_BITS-1:0];
      REG_IMG_HOT_Y: img_hot_y = val[HOT_BITS-1:0];
      default: ;
    endcase
    refresh_placement();
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: every accepted point queues its expected position, and every
  // accepted position is checked against the oldest one waiting. Both sides
  // are sampled at the clock edge, before any flop has updated.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cursor_pos_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_positions.push_back(place_cursor(in_point_x, in_point_y));
      if (out_valid && out_ready) begin
        if (pending_positions.size() == 0) begin
          $display("%0t: position item with none expected: x=%0d y=%0d",
                   $time, out_hw_pos_x, out_hw_pos_y);
          mismatch_count++;
        end else begin
          want = pending_positions.pop_front();
          if (out_hw_pos_x !== want.x) begin
            $display("%0t: hw_pos_x mismatch: expected %0d, got %0d",
                     $time, $signed(want.x), out_hw_pos_x);
            mismatch_count++;
          end
          if (out_hw_pos_y !== want.y) begin
            $display("%0t: hw_pos_y mismatch: expected %0d, got %0d",
                     $time, $signed(want.y), out_hw_pos_y);
            mismatch_count++;
          end
        end
      end
    end
  end

  // The receiver stalls at random, or solidly while a hold-off is counting
  // down.
  always @(posedge clk) begin
    if (ready_hold_left > 0) begin
      out_ready <= 1'b0;
      ready_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------

  // Offers one point item and returns at the edge where it is taken. Valid
  // is left high, so back-to-back items follow without a gap; it only drops
  // for a random idle gap or when the stream stops.
  task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering items and waits until every expected position has come.
  // The first edge lets the scoreboard queue an item taken at the last one.
  task automatic drain_positions();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_positions.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Writes one register once everything in flight has come out.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] val);
    drain_positions();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_placement(logic [CB-1:0] rot, logic [CB-1:0] w, logic [CB-1:0] h,
                               logic [CB-1:0] hx, logic [CB-1:0] hy,
                               logic [CB-1:0] ix, logic [CB-1:0] iy);
    write_reg(REG_ROTATION, rot);
    write_reg(REG_MODE_W, w);
    write_reg(REG_MODE_H, h);
    write_reg(REG_HOT_X, hx);
    write_reg(REG_HOT_Y, hy);
    write_reg(REG_IMG_HOT_X, ix);
    write_reg(REG_IMG_HOT_Y, iy);
  endtask

  // Coordinates lean towards the extremes and the zero crossing.
  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [CB-1:0] rand_rotation();
    logic [3:0] code;
    if ($urandom_range(3) == 0) return CB'($urandom);
    case ($urandom_range(3))
      0: code = ROT_0;
      1: code = ROT_90;
      2: code = ROT_180;
      default: code = ROT_270;
    endcase
    return {CB'($urandom_range(3)) << REFLECT_X_BIT} | CB'(code);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The reset placement, with points at the corners of the coordinate range and at zero and -1.
  task automatic test_extreme_points();
    send_point(16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h0000, 16'hffff);
    send_point(16'h7fff, 16'h8000);
    drain_positions();
  endtask

  // Each rotation code once, then words whose rotation nibble is not one-hot
  // and must behave as no rotation.
  task automatic test_rotation_codes();
    logic [3:0] nibbles[7];
    nibbles = '{ROT_0, ROT_90, ROT_180, ROT_270, 4'h0, 4'h3, ROT_NIBBLE_MASK};
    set_placement(CB'(ROT_0), 16'd1920, 16'd1080, 16'd100, -16'sd50, 16'd3, 16'd5);
    foreach (nibbles[i]) begin
      write_reg(REG_ROTATION, CB'(nibbles[i]));
      send_point(16'd37, -16'sd200);
      drain_positions();
    end
  endtask

  // Each reflect bit alone, with and without a quarter turn so that
  // the swapped meaning of the reflect bits is exercised.
  task automatic test_reflections();
    logic [3:0] codes[4];
    codes = '{ROT_0, ROT_90, ROT_270, 4'h5};
    foreach (codes[i]) begin
      write_reg(REG_ROTATION, (CB'(1) << REFLECT_X_BIT) | CB'(codes[i]));
      send_point(16'd12, 16'd400);
      write_reg(REG_ROTATION, (CB'(1) << REFLECT_Y_BIT) | CB'(codes[i]));
      send_point(-16'sd9, 16'd77);
      drain_positions();
    end
  endtask

  // Zero mode size, a write to an index that does not exist, and sums that
  // wrap at the result width.
  task automatic test_register_edges();
    set_placement(CB'(ROT_180), 16'd0, 16'd0, 16'd5, 16'd6, 16'd511, 16'd511);
    send_point(16'd1, 16'd2);
    drain_positions();
    write_reg(REG_UNUSED, 16'hffff);
    send_point(16'd1, 16'd2);
    drain_positions();
    set_placement(CB'(ROT_180), 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'd0, 16'd0);
    send_point(16'h8000, 16'h8000);
    write_reg(REG_ROTATION, CB'(ROT_0));
    write_reg(REG_HOT_X, 16'h7fff);
    write_reg(REG_HOT_Y, 16'h7fff);
    send_point(16'h7fff, 16'h7fff);
    drain_positions();
  endtask

  // The receiver holds off for a long stretch while points keep coming, so
  // the block fills and stalls its input; later the sender waits for every
  // position before going on.
  task automatic test_backpressure();
    set_placement(CB'(ROT_90), 16'd800, 16'd600, 16'd321, 16'd123, 16'd16, 16'd8);
    ready_hold_left = HOLD_OFF_CYCLES;
    repeat (30) send_point(rand_coord(), rand_coord());
    drain_positions();
    repeat (15) send_point(rand_coord(), rand_coord());
    drain_positions();
    repeat (15) send_point(rand_coord(), rand_coord());
    drain_positions();
  endtask

  // Random placements, each followed by a burst of random points.
  task automatic test_random_placements(int send_pct, int recv_pct, int rounds);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (rounds) begin
      write_reg(REG_ROTATION, rand_rotation());
      for (int r = int'(REG_MODE_W); r < NUM_REGS; r++)
        write_reg(CFG_IDX_BITS'(r), $urandom_range(1) ? CB'($urandom) : rand_coord());
      if ($urandom_range(3) == 0)
        write_reg(REG_UNUSED, CB'($urandom));
      repeat ($urandom_range(60, 100)) send_point(rand_coord(), rand_coord());
      drain_positions();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_ROTATION;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    out_ready  <= 1'b0;

    // The predictor starts from the reset placement.
    rot_word  = ROTATION_RST;
    mode_w    = (CB-1)'(MODE_W_RST);
    mode_h    = (CB-1)'(MODE_H_RST);
    src_hot_x = '0;
    src_hot_y = '0;
    img_hot_x = '0;
    img_hot_y = '0;
    refresh_placement();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_points();
    test_rotation_codes();
    test_reflections();
    test_register_edges();
    test_backpressure();
    test_random_placements(8, 48, 7);
    test_random_placements(48, 8, 7);
    test_random_placements(0, 0, 7);

    drain_positions();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_positions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cprr_pkg.sv
hw/rtl/cursor_position_rotate_reflect.sv
tb/cursor_position_rotate_reflect_test.sv
